FILE: design/svaloc_pkg.sv
// svaloc_pkg: shared constants, register indexes and the beat type that
// travels down the voice cell chain. No dependencies.
package svaloc_pkg;

  localparam int NUM_VOICES    = 64;
  localparam int TIME_INT_BITS = 40;
  localparam int FRAC_BITS     = 16;

  localparam int TIME_W = TIME_INT_BITS + FRAC_BITS;
  localparam int SPM_W  = 24;
  localparam int LEN_W  = 32;
  localparam int OFF_W  = 24;
  localparam int CNT_W  = 7;
  localparam int OFFQ_W = 16;
  localparam int VOUT_W = 7;
  localparam int CFG_W  = 24;
  localparam int CFG_IDX_W = 2;

  localparam int PROD_W = SPM_W + LEN_W;
  localparam int DUR_W  = PROD_W - FRAC_BITS;
  localparam int SUM_W  = ((TIME_W > DUR_W) ? TIME_W : DUR_W) + 1;
  localparam int VNUM_W = $clog2(NUM_VOICES + 1);
  localparam int ACT_W  = (VNUM_W > CNT_W) ? VNUM_W : CNT_W;
  localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_MS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_ACTIVE_IN  = 2'd2;

  localparam logic [SPM_W-1:0] SPM_RESET = 24'd3145728;
  localparam logic [CNT_W-1:0] ACT_RESET = 7'd64;

  typedef struct packed {
    logic              valid;
    logic              req;
    logic              restart;
    logic [TIME_W-1:0] now_q;
    logic [TIME_W-1:0] new_time;
    logic [ACT_W-1:0]  active;
    logic [VNUM_W-1:0] voice;
    logic [LEN_W-1:0]  len;
    logic [OFFQ_W-1:0] offq;
  } beat_t;

endpackage

FILE: design/svaloc_front.sv
// svaloc_front: config registers, sample clock, request decode and the
// busy-until time computation (multiply, add, subtract/saturate stages).
// Depends on svaloc_pkg.
module svaloc_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                cfg_we,
  input  logic [svaloc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [svaloc_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                                in_valid,
  input  logic                                in_trigger,
  input  logic [svaloc_pkg::LEN_W-1:0]        in_length_ms,
  input  logic signed [svaloc_pkg::OFF_W-1:0] in_subsample_offset,
  input  logic [svaloc_pkg::CNT_W-1:0]        in_active_count_in,
  input  logic                                in_restart,
  output svaloc_pkg::beat_t                   beat_o
);
  import svaloc_pkg::*;

  logic [SPM_W-1:0]         spm_r;
  logic [CNT_W-1:0]         act_cfg_r;
  logic                     use_in_r;
  logic [TIME_INT_BITS-1:0] clk_r, clk_nxt, clk_used;

  beat_t             a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic [PROD_W-1:0] a_prod_r;
  logic [SUM_W-1:0]  b_sum_r, b_sum_nxt, c_diff;
  logic [CNT_W-1:0]  act_raw;
  logic              accept;

  assign accept = in_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spm_r     <= SPM_RESET;
      act_cfg_r <= ACT_RESET;
      use_in_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLES_PER_MS: spm_r     <= cfg_wdata[SPM_W-1:0];
        CFG_ACTIVE_COUNT:   act_cfg_r <= cfg_wdata[CNT_W-1:0];
        CFG_USE_ACTIVE_IN:  use_in_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // restart zeroes the clock before this sample is processed
  always_comb begin
    clk_used = in_restart ? '0 : clk_r;
    clk_nxt  = (clk_used == '1) ? clk_used : clk_used + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_r <= '0;
    end else if (accept) begin
      clk_r <= clk_nxt;
    end
  end

  // stage A: decode, active count saturation, duration product
  always_comb begin
    act_raw = use_in_r ? in_active_count_in : act_cfg_r;
    a_nxt          = '0;
    a_nxt.valid    = in_valid;
    a_nxt.restart  = in_restart;
    a_nxt.req      = in_trigger && (in_subsample_offset[OFF_W-1] ||
                     (in_subsample_offset[OFF_W-2:FRAC_BITS] == '0));
    a_nxt.offq     = in_subsample_offset[OFF_W-1] ? '0 : in_subsample_offset[OFFQ_W-1:0];
    a_nxt.len      = in_length_ms;
    a_nxt.now_q    = {clk_used, {FRAC_BITS{1'b0}}};
    a_nxt.active   = (ACT_W'(act_raw) > ACT_W'(NUM_VOICES)) ? ACT_W'(NUM_VOICES)
                                                            : ACT_W'(act_raw);
  end

  // stage B: now + duration
  always_comb begin
    b_nxt     = a_r;
    b_sum_nxt = SUM_W'(a_r.now_q) + SUM_W'(a_prod_r[PROD_W-1:FRAC_BITS]);
  end

  // stage C: minus offset, floor at zero, saturate at the top
  always_comb begin
    c_nxt  = b_r;
    c_diff = b_sum_r - SUM_W'(b_r.offq);
    if (b_sum_r < SUM_W'(b_r.offq)) begin
      c_nxt.new_time = '0;
    end else if (c_diff[SUM_W-1:TIME_W] != '0) begin
      c_nxt.new_time = '1;
    end else begin
      c_nxt.new_time = c_diff[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
      c_r <= '0;
    end else if (adv) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_prod_r <= PROD_W'(spm_r) * PROD_W'(in_length_ms);
      b_sum_r  <= b_sum_nxt;
    end
  end

  assign beat_o = c_r;

  a_restart_clk: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_restart |=> clk_r == TIME_INT_BITS'(1))
    else $error("clock not restarted");

  a_clk_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(clk_r))
    else $error("clock moved without a beat");

  a_no_req_neg: assert property (@(posedge clk) disable iff (!rst_n)
    a_r.valid && a_r.offq != '0 |-> a_r.now_q[FRAC_BITS-1:0] == '0)
    else $error("clock fraction not zero");

endmodule

FILE: design/svaloc_cell.sv
// svaloc_cell: one voice. Holds that voice's free time, claims a passing
// request beat if eligible and hands the beat on. Depends on svaloc_pkg.
module svaloc_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic [svaloc_pkg::VIDX_W-1:0]  cell_idx,
  input  svaloc_pkg::beat_t              beat_i,
  output svaloc_pkg::beat_t              beat_o
);
  import svaloc_pkg::*;

  beat_t             beat_r, beat_nxt;
  logic [TIME_W-1:0] free_r, free_nxt, free_eff;
  logic              hit;

  always_comb begin
    free_eff = beat_i.restart ? '0 : free_r;
    hit = beat_i.valid && beat_i.req && (beat_i.voice == '0) &&
          (ACT_W'(cell_idx) < beat_i.active) && (free_eff <= beat_i.now_q);
    beat_nxt = beat_i;
    free_nxt = free_r;
    if (beat_i.valid && beat_i.restart) begin
      free_nxt = '0;
    end
    if (hit) begin
      beat_nxt.voice = VNUM_W'(cell_idx) + VNUM_W'(1);
      free_nxt       = beat_i.new_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
      free_r <= '0;
    end else if (adv) begin
      beat_r <= beat_nxt;
      free_r <= free_nxt;
    end
  end

  assign beat_o = beat_r;

endmodule

FILE: design/subsample_voice_allocator_top.sv
// subsample_voice_allocator_top: first-free voice allocator, one beat per
// sample. 67 register stages (3 front stages, then one per voice cell); out_valid
// comes from the last cell register. Throughput one beat per cycle while the
// consumer does not hold the output beat, set by the systolic voice chain.
// Reset (rst_n low, synchronous) frees every voice, zeroes the sample clock and
// loads config defaults. Depends on svaloc_pkg.
module subsample_voice_allocator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [svaloc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [svaloc_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_trigger,
  input  logic [svaloc_pkg::LEN_W-1:0]        in_length_ms,
  input  logic signed [svaloc_pkg::OFF_W-1:0] in_subsample_offset,
  input  logic [svaloc_pkg::CNT_W-1:0]        in_active_count_in,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [svaloc_pkg::VOUT_W-1:0]       out_voice_id,
  output logic [svaloc_pkg::LEN_W-1:0]        out_length_out,
  output logic [svaloc_pkg::OFFQ_W-1:0]       out_offset_out
);
  import svaloc_pkg::*;

  // chain[0] comes from the front end; chain[NUM_VOICES] is the output beat
  beat_t chain [NUM_VOICES+1];
  logic  adv;
  logic  found;

  // The whole pipe moves together; it only stalls when the output beat is
  // held by the consumer. Items follow each other one cell apart, so each
  // beat sees the free times left by every earlier beat (wavefront order).
  assign adv      = !chain[NUM_VOICES].valid || out_ready;
  assign in_ready = adv;

  svaloc_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .adv                 (adv),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_trigger          (in_trigger),
    .in_length_ms        (in_length_ms),
    .in_subsample_offset (in_subsample_offset),
    .in_active_count_in  (in_active_count_in),
    .in_restart          (in_restart),
    .beat_o              (chain[0])
  );

  // one cell per voice, voice i+1 owned by cell i
  for (genvar i = 0; i < NUM_VOICES; i++) begin : g_cell
    svaloc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (VIDX_W'(i)),
      .beat_i   (chain[i]),
      .beat_o   (chain[i+1])
    );
  end

  // final cell register doubles as the output register
  assign found          = chain[NUM_VOICES].voice != '0;
  assign out_valid      = chain[NUM_VOICES].valid;
  assign out_voice_id   = VOUT_W'(chain[NUM_VOICES].voice);
  assign out_length_out = found ? chain[NUM_VOICES].len  : '0;
  assign out_offset_out = found ? chain[NUM_VOICES].offq : '0;

  a_zero_when_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> out_length_out == '0 && out_offset_out == '0)
    else $error("payload on a beat with no voice");

  a_voice_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> chain[NUM_VOICES].voice <= VNUM_W'(NUM_VOICES))
    else $error("voice number out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(chain[NUM_VOICES/2].valid) && $stable(chain[0].valid))
    else $error("chain moved during stall");

  a_found_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found |-> chain[NUM_VOICES].req)
    else $error("voice assigned without request");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for subsample_voice_allocator_top, first-free voice allocation
// with a per-beat allocation predictor, directed table plus random phases.
// Depends on svaloc_pkg and the allocator RTL.
module testbench;
  import svaloc_pkg::*;

  localparam int          SUM_BITS    = TIME_W + 1;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          N_PHASES    = 6;
  localparam int          SQUEEZE_LEN = 300;  // long out_ready hold-off, in cycles
  localparam int          TAIL_CYCLES = 80;   // pipeline is 67 deep, plus margin

  // one input beat and one result beat
  typedef struct packed {
    logic              trigger;
    logic [LEN_W-1:0]  length;
    logic [OFF_W-1:0]  offset;
    logic [CNT_W-1:0]  count;
    logic              restart;
  } sample_t;

  typedef struct packed {
    logic [VOUT_W-1:0] voice;
    logic [LEN_W-1:0]  length;
    logic [OFFQ_W-1:0] offset;
  } alloc_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  // one line of the directed table: either a register write or a sample beat,
  // the latter with an optional hand-typed result
  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_W-1:0]      reg_value;
    sample_t               smp;
    bit                    known;
    alloc_t                want;
  } plan_row_t;

  // DUT ports
  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_wdata;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_trigger;
  logic [LEN_W-1:0]        in_length_ms;
  logic signed [OFF_W-1:0] in_subsample_offset;
  logic [CNT_W-1:0]        in_active_count_in;
  logic                    in_restart;
  logic                    out_valid;
  logic                    out_ready;
  logic [VOUT_W-1:0]       out_voice_id;
  logic [LEN_W-1:0]        out_length_out;
  logic [OFFQ_W-1:0]       out_offset_out;

  // predictor state: per-voice busy-until time (Q40.16) and the sample counter
  logic [TIME_W-1:0]        busy_until [NUM_VOICES];
  logic [TIME_INT_BITS-1:0] sample_index;
  // predictor copy of the registers
  logic [SPM_W-1:0]         rate_spm;
  logic [CNT_W-1:0]         voices_reg;
  logic                     count_from_input;

  alloc_t      pending_allocs [$];  // expected results, oldest first
  alloc_t      head_alloc;
  plan_row_t   directed_plan [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  bit          squeeze_go   = 1'b0;
  bit          squeeze_done = 1'b0;

  subsample_voice_allocator_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_trigger          (in_trigger),
    .in_length_ms        (in_length_ms),
    .in_subsample_offset (in_subsample_offset),
    .in_active_count_in  (in_active_count_in),
    .in_restart          (in_restart),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_voice_id        (out_voice_id),
    .out_length_out      (out_length_out),
    .out_offset_out      (out_offset_out)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Allocation predictor. Runs once per accepted beat, in acceptance order.
  task automatic allocate_voice(input sample_t s, output alloc_t r);
    int unsigned       n_active;
    int                hit;
    logic [TIME_W-1:0] now_q;
    logic [PROD_W-1:0] prod;
    logic [SUM_BITS-1:0] t;
    logic [OFFQ_W-1:0] offq;
    r   = '0;
    hit = -1;
    // restart clears everything before the beat is looked at
    if (s.restart) begin
      foreach (busy_until[i]) busy_until[i] = '0;
      sample_index = '0;
    end
    n_active = count_from_input ? s.count : voices_reg;
    if (n_active > NUM_VOICES) n_active = NUM_VOICES;
    now_q = {sample_index, {FRAC_BITS{1'b0}}};
    // request only if offset < 1.0: negative, or integer part zero
    if (s.trigger && (s.offset[OFF_W-1] || s.offset[OFF_W-2:FRAC_BITS] == '0)) begin
      for (int v = 0; v < n_active; v++)
        if (hit < 0 && busy_until[v] <= now_q) hit = v;
      if (hit >= 0) begin
        offq = s.offset[OFF_W-1] ? '0 : s.offset[OFFQ_W-1:0];
        // duration = floor(rate * length) in Q.16
        prod = PROD_W'(rate_spm) * PROD_W'(s.length);
        t    = SUM_BITS'(now_q) + SUM_BITS'(prod >> FRAC_BITS);
        t    = (t < SUM_BITS'(offq)) ? '0 : t - SUM_BITS'(offq);
        busy_until[hit] = t[TIME_W] ? '1 : t[TIME_W-1:0];
        r.voice  = VOUT_W'(hit + 1);
        r.length = s.length;
        r.offset = offq;
      end
    end
    if (sample_index != '1) sample_index = sample_index + 1'b1;
  endtask

  // Offer one beat, hold it until accepted, then log its expected result.
  task automatic push_sample(input sample_t s, input bit known, input alloc_t typed);
    alloc_t got;
    in_valid            <= 1'b1;
    in_trigger          <= s.trigger;
    in_length_ms        <= s.length;
    in_subsample_offset <= s.offset;
    in_active_count_in  <= s.count;
    in_restart          <= s.restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    allocate_voice(s, got);
    pending_allocs.push_back(known ? typed : got);
  endtask

  // Drop valid and wait for the pipeline to empty; every beat gives a result,
  // so an empty queue means the block is idle.
  task automatic drain_allocs();
    in_valid <= 1'b0;
    while (pending_allocs.size() != 0) @(posedge clk);
  endtask

  // Register write: one cycle with cfg_we high, then cfg_we low before the predictor copy updates.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SAMPLES_PER_MS: rate_spm         = val[SPM_W-1:0];
      CFG_ACTIVE_COUNT:   voices_reg       = val[CNT_W-1:0];
      CFG_USE_ACTIVE_IN:  count_from_input = val[0];
      default: ;
    endcase
  endtask

  // Sender pacing: bursts of random length, random gaps between them.
  // Long bursts give stretches with no idling at all.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap        = $urandom_range(0, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic void plan_item(input logic trig, input logic [LEN_W-1:0] len,
                                    input logic [OFF_W-1:0] off, input logic [CNT_W-1:0] cnt,
                                    input logic rst, input bit known,
                                    input logic [VOUT_W-1:0] v, input logic [LEN_W-1:0] l,
                                    input logic [OFFQ_W-1:0] o);
    plan_row_t row;
    row.kind      = ROW_SAMPLE;
    row.reg_index = '0;
    row.reg_value = '0;
    row.smp       = '{trig, len, off, cnt, rst};
    row.known     = known;
    row.want      = '{v, l, o};
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    plan_row_t row;
    row.kind      = ROW_WRITE;
    row.reg_index = idx;
    row.reg_value = val;
    row.smp       = '0;
    row.known     = 1'b0;
    row.want      = '0;
    directed_plan.push_back(row);
  endfunction

  // Random beat. Most offsets are valid requests so voices actually get used;
  // lengths are mostly short so voices free up again within a phase.
  function automatic sample_t random_sample();
    sample_t     s;
    int unsigned pick;
    s.trigger = ($urandom_range(0, 3) != 0);
    s.restart = ($urandom_range(0, 39) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 60)      s.offset = OFF_W'($urandom_range(0, 16'hFFFF));
    else if (pick < 75) s.offset = {1'b1, (OFF_W-1)'($urandom)};            // negative
    else if (pick < 90) s.offset = OFF_W'($urandom_range(24'h010000, 24'h7FFFFF)); // >= 1.0
    else                s.offset = OFF_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30)      s.length = $urandom_range(0, 32'h2000);
    else if (pick < 80) s.length = $urandom_range(0, 32'h4_0000);
    else if (pick < 95) s.length = $urandom_range(0, 32'hFF_FFFF);
    else                s.length = $urandom;
    if (count_from_input && $urandom_range(0, 9) < 7)
      s.count = CNT_W'($urandom_range(1, 8));
    else
      s.count = CNT_W'($urandom_range(0, 127));
    return s;
  endfunction

  // Result checker: every out beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_allocs.size() == 0) begin
        $error("result beat with no expectation pending: voice %0d", out_voice_id);
        error_count++;
      end else begin
        head_alloc = pending_allocs.pop_front();
        if (out_voice_id !== head_alloc.voice) begin
          $error("voice_id: expected %0d, got %0d", head_alloc.voice, out_voice_id);
          error_count++;
        end
        if (out_length_out !== head_alloc.length) begin
          $error("length_out: expected %h, got %h", head_alloc.length, out_length_out);
          error_count++;
        end
        if (out_offset_out !== head_alloc.offset) begin
          $error("offset_out: expected %h, got %h", head_alloc.offset, out_offset_out);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** subsample_voice_allocator_top: FAILED **");
      $finish;
    end
  end

  // Result sink. Stall pattern is picked at random from: always ready, coin
  // flip, one stall in five, or long-ish stalls. Once, at the start of the
  // first random phase, it holds out_ready low long enough for the voice chain
  // to fill up and in_ready to drop while the sender keeps offering beats.
  initial begin : result_sink
    int unsigned tick;
    int unsigned mode;
    tick = 0;
    mode = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_go && !squeeze_done) begin
        squeeze_done = 1'b1;
        out_ready <= 1'b0;
        repeat (SQUEEZE_LEN) @(posedge clk);
      end else begin
        tick++;
        if (tick % 48 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= (tick % 5 != 0);
          default: out_ready <= (tick % 16 >= 6);
        endcase
      end
    end
  end

  // Stimulus.
  initial begin
    logic [CFG_W-1:0] ph_rate;
    logic [CFG_W-1:0] ph_voices;
    logic [CFG_W-1:0] ph_use_in;
    int unsigned      ph_items;

    // predictor matches the reset state: all voices free, default registers
    foreach (busy_until[i]) busy_until[i] = '0;
    sample_index     = '0;
    rate_spm         = SPM_RESET;
    voices_reg       = ACT_RESET;
    count_from_input = 1'b0;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_wdata           <= '0;
    in_valid            <= 1'b0;
    in_trigger          <= 1'b0;
    in_length_ms        <= '0;
    in_subsample_offset <= '0;
    in_active_count_in  <= '0;
    in_restart          <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table. Typed results only where obvious; the rest go through
    // the predictor. Default registers: 48 samples/ms, 64 voices, count from reg.
    //        trig  length        offset      cnt    rst  typed voice  length        offset
    plan_item(1'b1, 32'h0001_0000, 24'h000000, 7'd0,   1'b0, 1'b1, 7'd1, 32'h0001_0000, 16'h0000);
    // most negative offset clamps to zero, max length
    plan_item(1'b1, 32'hFFFF_FFFF, 24'h800000, 7'd0,   1'b0, 1'b1, 7'd2, 32'hFFFF_FFFF, 16'h0000);
    // offset exactly 1.0 and the largest offset: request ignored
    plan_item(1'b1, 32'h0001_0000, 24'h010000, 7'd0,   1'b0, 1'b1, 7'd0, 32'h0,         16'h0000);
    plan_item(1'b1, 32'h0001_0000, 24'h7FFFFF, 7'h7F,  1'b0, 1'b1, 7'd0, 32'h0,         16'h0000);
    // no trigger
    plan_item(1'b0, 32'h0000_1234, 24'h000000, 7'd0,   1'b0, 1'b1, 7'd0, 32'h0,         16'h0000);
    // largest accepted offset, zero length
    plan_item(1'b1, 32'h0000_0000, 24'h00FFFF, 7'd0,   1'b0, 1'b1, 7'd3, 32'h0,         16'hFFFF);
    plan_item(1'b1, 32'h0000_8000, 24'h008000, 7'd0,   1'b0, 1'b0, 7'd0, 32'h0,         16'h0000);
    // restart frees all voices: voice 1 again
    plan_item(1'b1, 32'h0001_0000, 24'h000000, 7'd0,   1'b1, 1'b1, 7'd1, 32'h0001_0000, 16'h0000);
    plan_item(1'b0, 32'hFFFF_FFFF, 24'hFFFFFF, 7'h7F,  1'b1, 1'b1, 7'd0, 32'h0,         16'h0000);
    // two voices only: fill both with endless notes, third request finds none
    plan_write(CFG_ACTIVE_COUNT, 24'd2);
    plan_item(1'b1, 32'hFFFF_FFFF, 24'h000000, 7'd0,   1'b0, 1'b1, 7'd1, 32'hFFFF_FFFF, 16'h0000);
    plan_item(1'b1, 32'hFFFF_FFFF, 24'h000000, 7'd0,   1'b0, 1'b1, 7'd2, 32'hFFFF_FFFF, 16'h0000);
    plan_item(1'b1, 32'h0001_0000, 24'h000000, 7'd0,   1'b0, 1'b1, 7'd0, 32'h0,         16'h0000);
    // count from input: 127 saturates to all voices, 0 assigns nothing
    plan_write(CFG_USE_ACTIVE_IN, 24'd1);
    plan_item(1'b1, 32'h0001_0000, 24'h000000, 7'h7F,  1'b1, 1'b1, 7'd1, 32'h0001_0000, 16'h0000);
    plan_item(1'b1, 32'h0001_0000, 24'h000000, 7'd0,   1'b0, 1'b1, 7'd0, 32'h0,         16'h0000);
    plan_item(1'b1, 32'h0001_0000, 24'h004000, 7'd64,  1'b0, 1'b0, 7'd0, 32'h0,         16'h0000);
    // zero rate: notes end at once
    plan_write(CFG_SAMPLES_PER_MS, 24'd0);
    plan_write(CFG_USE_ACTIVE_IN, 24'd0);
    plan_write(CFG_ACTIVE_COUNT, 24'd64);
    plan_item(1'b1, 32'hFFFF_FFFF, 24'h000000, 7'd0,   1'b0, 1'b0, 7'd0, 32'h0,         16'h0000);
    plan_item(1'b1, 32'h0001_0000, 24'h000000, 7'd0,   1'b0, 1'b0, 7'd0, 32'h0,         16'h0000);
    // max rate times max length: largest product
    plan_write(CFG_SAMPLES_PER_MS, 24'hFFFFFF);
    plan_item(1'b1, 32'hFFFF_FFFF, 24'hFFFFFF, 7'd0,   1'b0, 1'b0, 7'd0, 32'h0,         16'h0000);
    plan_item(1'b1, 32'h0000_0001, 24'h000001, 7'd0,   1'b0, 1'b0, 7'd0, 32'h0,         16'h0000);
    plan_item(1'b1, 32'hAAAA_5555, 24'h00A5A5, 7'h55,  1'b0, 1'b0, 7'd0, 32'h0,         16'h0000);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_WRITE) begin
        drain_allocs();
        write_reg(directed_plan[i].reg_index, directed_plan[i].reg_value);
      end else begin
        push_sample(directed_plan[i].smp, directed_plan[i].known, directed_plan[i].want);
      end
    end

    // Random phases, each with its own register setting. Registers only
    // change once the pipeline has drained.
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       begin ph_rate = 24'd3145728; ph_voices = 24'd64; ph_use_in = 24'd0; ph_items = 120; end
        1:       begin ph_rate = 24'd65536;   ph_voices = 24'd43; ph_use_in = 24'd0; ph_items = 70;  end
        2:       begin ph_rate = 24'd0;       ph_voices = 24'd1;  ph_use_in = 24'd0; ph_items = 30;  end
        3:       begin ph_rate = 24'hFFFFFF;  ph_voices = 24'd64; ph_use_in = 24'd1; ph_items = 70;  end
        4:       begin ph_rate = 24'd1;       ph_voices = 24'd0;  ph_use_in = 24'd0; ph_items = 20;  end
        default: begin ph_rate = 24'd655360;  ph_voices = 24'd16; ph_use_in = 24'd1; ph_items = 80;  end
      endcase
      drain_allocs();
      write_reg(CFG_SAMPLES_PER_MS, ph_rate);
      write_reg(CFG_ACTIVE_COUNT, ph_voices);
      write_reg(CFG_USE_ACTIVE_IN, ph_use_in);
      if (p == 0) squeeze_go = 1'b1;  // backpressure test rides on the first phase
      for (int k = 0; k < ph_items; k++) begin
        push_sample(random_sample(), 1'b0, '0);
        pace_sender();
      end
    end

    drain_allocs();
    repeat (TAIL_CYCLES) @(posedge clk);  // catch any stray extra beats
    if (error_count == 0)
      $display("** subsample_voice_allocator_top: PASSED **");
    else
      $display("** subsample_voice_allocator_top: FAILED **");
    $finish;
  end

endmodule
